// ===== hdl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Phase and status codes and header field constants shared by the deframer
// and its checker.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int unsigned COUNT_WIDTH = 17;
    localparam int unsigned CAP_WIDTH   = 17;

    localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(64 * 1024);

    localparam logic [3:0] OPCODE_MASK  = 4'hF;
    localparam logic [3:0] OPCODE_CLOSE = 4'h8;
    localparam int unsigned MASK_BIT    = 7;
    localparam logic [6:0] LEN7_MASK    = 7'h7F;
    localparam logic [6:0] LEN_EXT16    = 7'd126;
    localparam logic [6:0] LEN_EXT64    = 7'd127;

    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] MASK_LAST  = 3'd3;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_MASK    = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_HALTED  = 3'd6,
        PH_CLOSING = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        ST_DATA     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_CLOSE    = 2'd2,
        ST_OVERSIZE = 2'd3
    } t_status;

endpackage

// ===== hdl/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses received frame headers one byte at a time and puts out unmasked
// payload bytes, empty-message markers and error markers.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one received byte per item on i_s_axis_tdata.
//   Master stream: tdata is the payload byte, tlast marks the final payload
//   byte or an empty message, tuser is the status (0 data, 1 empty message,
//   2 close frame, 3 length over cap).
//   i_cfg_we / i_cfg_wdata write the payload length cap; write it only
//   while no item is in flight.
//   The phase, length and key registers and the output register all update on
//   the accepting edge; one byte is taken every cycle unless the receiver
//   stalls a held result. Header, length and mask key bytes give no payload;
//   the last of them may give the empty or oversize marker.
//   After a close frame or an oversize length one error item is given and
//   every later byte is taken and dropped until reset.
//   Reset puts the parser at the first header byte, empties the output
//   register and sets the cap to 65536.
//   When the receiver stalls with a result held, o_s_axis_tready drops; a
//   free or draining output register keeps the input running.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
    parameter int unsigned COUNT_WIDTH = wsd_pkg::COUNT_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wsd_pkg::CAP_WIDTH-1:0]  i_cfg_wdata,     // max_payload_bytes
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // byte_in
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [7:0]                     o_m_axis_tdata,  // payload_byte
    output logic                           o_m_axis_tlast,  // last_of_message
    output logic [1:0]                     o_m_axis_tuser   // status
);
    import wsd_pkg::*;

    localparam int unsigned CW    = COUNT_WIDTH;
    localparam int unsigned CMP_W = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;

    t_phase                 r_phase, n_phase;
    logic [CAP_WIDTH-1:0]   r_cap;
    logic [CW-1:0]          r_len, n_len;
    logic                   r_len_hi, n_len_hi;
    logic [2:0]             r_cnt, n_cnt;
    logic [31:0]            r_key, n_key;
    logic                   r_mask_on, n_mask_on;
    logic [CW-1:0]          r_left, n_left;
    logic [1:0]             r_lane, n_lane;

    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_out_data, n_out_data;
    logic                   r_out_last, n_out_last;
    t_status                r_out_status, n_out_status;

    logic                   w_acc;
    logic [7:0]             w_b;
    logic [6:0]             w_len7;
    logic                   w_len_done;
    logic [CW-1:0]          w_len_val;
    logic                   w_len_hi;
    logic [CMP_W-1:0]       w_cap;
    logic [CMP_W-1:0]       w_cnt_max;
    logic                   w_over;
    logic                   w_mask_next;
    logic                   w_mask_done;
    logic                   w_begin;
    logic [CW-1:0]          w_begin_left;
    logic [CW-1:0]          w_left_dec;
    logic [7:0]             w_key_byte;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign w_b             = i_s_axis_tdata;
    assign w_len7          = w_b[6:0] & LEN7_MASK;

    // length assembly: low bits kept, anything shifted above them is sticky
    always_comb begin
        w_len_done = 1'b0;
        w_len_val  = CW'({r_len, w_b});
        w_len_hi   = r_len_hi || (r_len[CW-1 -: 8] != 8'd0);
        unique case (r_phase)
            PH_HDR1: begin
                w_len_done = (w_len7 != LEN_EXT16) && (w_len7 != LEN_EXT64);
                w_len_val  = w_len_done ? CW'(w_len7) : '0;
                w_len_hi   = 1'b0;
            end
            PH_EXT16: w_len_done = (r_cnt == EXT16_LAST);
            PH_EXT64: w_len_done = (r_cnt == EXT64_LAST);
            default:  w_len_done = 1'b0;
        endcase
    end

    assign w_cnt_max    = CMP_W'({CW{1'b1}});
    assign w_cap        = (CMP_W'(r_cap) < w_cnt_max) ? CMP_W'(r_cap) : w_cnt_max;
    assign w_over       = w_len_hi || (CMP_W'(w_len_val) > w_cap);
    assign w_mask_next  = (r_phase == PH_HDR1) ? w_b[MASK_BIT] : r_mask_on;
    assign w_mask_done  = (r_phase == PH_MASK) && (r_cnt == MASK_LAST);
    assign w_begin      = (w_len_done && !w_over && !w_mask_next) || w_mask_done;
    assign w_begin_left = w_mask_done ? r_left : w_len_val;
    assign w_left_dec   = r_left - CW'(1);
    assign w_key_byte   = r_key[{~r_lane, 3'b000} +: 8];

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HDR0: begin
                n_phase = ((w_b[3:0] & OPCODE_MASK) == OPCODE_CLOSE) ? PH_CLOSING : PH_HDR1;
            end
            PH_CLOSING: n_phase = PH_HALTED;
            PH_HDR1, PH_EXT16, PH_EXT64, PH_MASK: begin
                if (r_phase == PH_HDR1 && w_len7 == LEN_EXT16) begin
                    n_phase = PH_EXT16;
                end else if (r_phase == PH_HDR1 && w_len7 == LEN_EXT64) begin
                    n_phase = PH_EXT64;
                end
                if (w_len_done && w_over) begin
                    n_phase = PH_HALTED;
                end else if (w_len_done && w_mask_next) begin
                    n_phase = PH_MASK;
                end else if (w_begin) begin
                    n_phase = (w_begin_left == '0) ? PH_HDR0 : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: n_phase = (w_left_dec == '0) ? PH_HDR0 : PH_PAYLOAD;
            PH_HALTED:  n_phase = PH_HALTED;
        endcase
    end

    // datapath and result
    always_comb begin
        n_len        = r_len;
        n_len_hi     = r_len_hi;
        n_cnt        = r_cnt;
        n_key        = r_key;
        n_mask_on    = r_mask_on;
        n_left       = r_left;
        n_lane       = r_lane;
        n_out_valid  = 1'b0;
        n_out_data   = 8'd0;
        n_out_last   = 1'b0;
        n_out_status = ST_DATA;
        unique case (r_phase)
            PH_HDR0, PH_HALTED: begin
            end
            PH_CLOSING: begin
                n_out_valid  = 1'b1;
                n_out_status = ST_CLOSE;
            end
            PH_HDR1, PH_EXT16, PH_EXT64, PH_MASK: begin
                if (r_phase == PH_HDR1) begin
                    n_mask_on = w_b[MASK_BIT];
                    n_key     = 32'd0;
                    n_cnt     = 3'd0;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
                if (r_phase == PH_MASK) begin
                    n_key = {r_key[23:0], w_b};
                end else begin
                    n_len    = w_len_val;
                    n_len_hi = w_len_hi;
                end
                if (w_len_done) begin
                    n_cnt  = 3'd0;
                    n_left = w_len_val;
                    if (w_over) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_OVERSIZE;
                    end
                end
                if (w_begin) begin
                    n_lane = 2'd0;
                    if (w_begin_left == '0) begin
                        n_out_valid  = 1'b1;
                        n_out_last   = 1'b1;
                        n_out_status = ST_EMPTY;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_lane      = r_lane + 2'd1;
                n_left      = w_left_dec;
                n_out_valid = 1'b1;
                n_out_data  = w_b ^ w_key_byte;
                n_out_last  = (w_left_dec == '0);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR0;
            r_cap       <= CAP_RESET;
            r_len       <= '0;
            r_len_hi    <= 1'b0;
            r_cnt       <= 3'd0;
            r_key       <= 32'd0;
            r_mask_on   <= 1'b0;
            r_left      <= '0;
            r_lane      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (w_acc) begin
                r_phase     <= n_phase;
                r_len       <= n_len;
                r_len_hi    <= n_len_hi;
                r_cnt       <= n_cnt;
                r_key       <= n_key;
                r_mask_on   <= n_mask_on;
                r_left      <= n_left;
                r_lane      <= n_lane;
                r_out_valid <= n_out_valid;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out_data   <= n_out_data;
            r_out_last   <= n_out_last;
            r_out_status <= n_out_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_status;

endmodule

// ===== hdl/wsd_checker.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer port checker
// Watches the top-level ports for reset behaviour, output stalls and
// consistency between status, data and end-of-message marking.
// ----------------------------------------------------------------------------
module wsd_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    input  logic [7:0]                     o_m_axis_tdata,
    input  logic                           o_m_axis_tlast,
    input  logic [1:0]                     o_m_axis_tuser
);
    import wsd_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
            && $stable(o_m_axis_tuser))
        else $error("stalled output item changed");

    a_nondata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ST_DATA |-> o_m_axis_tdata == 8'd0)
        else $error("non-data item carries data");

    a_error_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == ST_CLOSE || o_m_axis_tuser == ST_OVERSIZE)
            |-> !o_m_axis_tlast)
        else $error("error item marked last");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_EMPTY |-> o_m_axis_tlast)
        else $error("empty message not marked last");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
